// ----- rtl/mec_pkg.sv -----
// Shared constants and types for the Mandelbrot escape-time counter.
`default_nettype none

package mec_pkg;

    localparam int unsigned COL_W      = 9;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 16;

    localparam int unsigned MAX_POINTS = 512;
    localparam int unsigned FRAC_W     = 30;

    localparam int unsigned MUL_W  = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned CR_W   = 42;
    localparam int unsigned ZW     = 44;

    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_START = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_STEP  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ITER_CAP   = 2'd2;

    localparam logic [COORD_W-1:0] RST_REAL_START = 32'h8000_0000;
    localparam logic [COORD_W-1:0] RST_REAL_STEP  = 32'h0000_0000;
    localparam logic [CNT_W-1:0]   RST_ITER_CAP   = 16'd256;

    typedef struct packed {
        logic signed [COORD_W-1:0] real_start;
        logic signed [COORD_W-1:0] real_step;
        logic [CNT_W-1:0]          iter_cap;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic ack;
    } t_iter_ctl;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] count;
    } t_iter_stat;

endpackage

`default_nettype wire

// ----- rtl/mec_mul.sv -----
// Shared unsigned 32x32 multiplier with registered product.
`default_nettype none

module mec_mul (
    input  logic                        i_clk,
    input  logic [mec_pkg::MUL_W-1:0]   i_a,
    input  logic [mec_pkg::MUL_W-1:0]   i_b,
    output logic [mec_pkg::PROD_W-1:0]  o_p
);
    import mec_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ----- rtl/mec_iter.sv -----
// Iteration sequencer and datapath: z = z*z + c on one shared multiplier.
`default_nettype none

module mec_iter #(
    parameter int unsigned MAX_POINTS = mec_pkg::MAX_POINTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mec_pkg::t_iter_ctl                 i_ctl,
    input  mec_pkg::t_cfg                      i_cfg,
    input  logic [mec_pkg::COL_W-1:0]          i_col,
    input  logic signed [mec_pkg::COORD_W-1:0] i_ci,
    output mec_pkg::t_iter_stat                o_stat
);
    import mec_pkg::*;

    localparam int unsigned DW     = PROD_W + 1;
    localparam int unsigned SQ_W   = PROD_W - FRAC_W;
    localparam int unsigned NX_W   = DW - FRAC_W;
    localparam int unsigned NY_W   = DW - (FRAC_W - 1);
    localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_CRW  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_M1   = 4'd4;
    localparam logic [3:0] S_M2   = 4'd5;
    localparam logic [3:0] S_M3   = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [COL_W-1:0]          r_col;
    logic signed [COORD_W-1:0] r_ci;
    logic signed [CR_W-1:0]    r_cr;
    logic signed [ZW-1:0]      r_x, r_y;
    logic [PROD_W-1:0]         r_xx, r_yy;
    logic signed [DW-1:0]      r_d, r_xy;

    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [PROD_W-1:0]  w_p;
    logic [MUL_W-1:0]   w_step_mag;
    logic [ZW-1:0]      w_ax, w_ay;
    logic               w_big;
    logic               w_col_bad;
    logic [SQ_W:0]      w_sq_sum;
    logic               w_escape;
    logic [CR_W-1:0]    w_cr_term;
    logic [CR_W-1:0]    w_cr;
    logic [DW-1:0]      w_p_ext;
    logic signed [ZW-1:0] w_nx, w_ny;

    mec_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    assign w_step_mag = i_cfg.real_step[COORD_W-1] ? (~i_cfg.real_step + 1'b1)
                                                   : i_cfg.real_step;
    assign w_ax  = r_x[ZW-1] ? (~r_x + 1'b1) : r_x;
    assign w_ay  = r_y[ZW-1] ? (~r_y + 1'b1) : r_y;
    assign w_big = (|w_ax[ZW-1:MUL_W]) | (|w_ay[ZW-1:MUL_W]);
    assign w_col_bad = 32'(i_col) >= MAX_POINTS;

    // c_r = real_start + col * real_step; the product magnitude fits 41 bits
    assign w_cr_term = {1'b0, w_p[CR_W-2:0]};
    assign w_cr = {{(CR_W - COORD_W){i_cfg.real_start[COORD_W-1]}}, i_cfg.real_start}
                + (i_cfg.real_step[COORD_W-1] ? (~w_cr_term + 1'b1) : w_cr_term);

    assign w_sq_sum = {1'b0, r_xx[PROD_W-1:FRAC_W]} + {1'b0, r_yy[PROD_W-1:FRAC_W]};
    assign w_escape = w_sq_sum > ESC_LIMIT;

    assign w_p_ext = {1'b0, w_p};

    assign w_nx = {{(ZW - NX_W){r_d[DW-1]}}, r_d[DW-1:FRAC_W]}
                + {{(ZW - CR_W){r_cr[CR_W-1]}}, r_cr};
    assign w_ny = {{(ZW - NY_W){r_xy[DW-1]}}, r_xy[DW-1:FRAC_W-1]}
                + {{(ZW - COORD_W){r_ci[COORD_W-1]}}, r_ci};

    always_comb begin
        case (r_state)
            S_CR: begin
                w_mul_a = MUL_W'(r_col);
                w_mul_b = w_step_mag;
            end
            S_CHK: begin
                w_mul_a = w_ax[MUL_W-1:0];
                w_mul_b = w_ax[MUL_W-1:0];
            end
            S_M1: begin
                w_mul_a = w_ay[MUL_W-1:0];
                w_mul_b = w_ay[MUL_W-1:0];
            end
            default: begin
                w_mul_a = w_ax[MUL_W-1:0];
                w_mul_b = w_ay[MUL_W-1:0];
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_cnt   = '0;
                    n_state = w_col_bad ? S_DONE : S_CR;
                end
            end
            S_CR:  n_state = S_CRW;
            S_CRW: begin
                n_cnt   = '0;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_cnt >= i_cfg.iter_cap || w_big) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_M1;
                end
            end
            S_M1: n_state = S_M2;
            S_M2: n_state = S_M3;
            S_M3: n_state = w_escape ? S_DONE : S_UPD;
            S_UPD: begin
                n_cnt   = r_cnt + 1'b1;
                n_state = S_CHK;
            end
            S_DONE: begin
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_ctl.start) begin
            r_col <= i_col;
            r_ci  <= i_ci;
        end
        if (r_state == S_CRW) begin
            r_cr <= w_cr;
            r_x  <= '0;
            r_y  <= '0;
        end
        if (r_state == S_M1) begin
            r_xx <= w_p;
        end
        if (r_state == S_M2) begin
            r_yy <= w_p;
            r_d  <= {1'b0, r_xx} - w_p_ext;
        end
        if (r_state == S_M3) begin
            r_xy <= (r_x[ZW-1] ^ r_y[ZW-1]) ? (~w_p_ext + 1'b1) : w_p_ext;
        end
        if (r_state == S_UPD) begin
            r_x <= w_nx;
            r_y <= w_ny;
        end
    end

    assign o_stat.busy  = r_state != S_IDLE;
    assign o_stat.done  = r_state == S_DONE;
    assign o_stat.count = r_cnt;

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_counter_core.sv -----
// Top level: configuration registers, stream ports and result register.
//
// Each input beat is one point; the core computes c_r = real_start + column * real_step
// and iterates z = z*z + c in Q2.30 until escape or the iteration cap, then returns the
// count. All arithmetic runs on one shared 32x32 multiplier, which sets the rate: a point
// forms c_r first (product, then sum), then each iteration runs the cap check, three
// products with the escape test, and the update; a run ends at the check when the cap or
// a huge z stops it, or after the escape test, and the count is handed over from a done
// state. A column at or above MAX_POINTS goes straight to hand-over with a count of zero.
// One point is in work at a time; the input is ready again once the count moves into the
// output register, even while that result waits to be taken. Configuration must be
// written only while idle; the block itself does not enforce this.
`default_nettype none

module mandelbrot_escape_counter_core #(
    parameter int unsigned MAX_POINTS = mec_pkg::MAX_POINTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mec_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [mec_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [8:0] column_index, [40:9] imag_coord, [47:41] zero
    input  logic [mec_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] iteration_count
    output logic [mec_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import mec_pkg::*;

    t_cfg       r_cfg;
    t_iter_ctl  w_ctl;
    t_iter_stat w_stat;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_start <= RST_REAL_START;
            r_cfg.real_step  <= RST_REAL_STEP;
            r_cfg.iter_cap   <= RST_ITER_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_REAL_START: r_cfg.real_start <= i_cfg_wdata;
                CFG_REAL_STEP:  r_cfg.real_step  <= i_cfg_wdata;
                CFG_ITER_CAP:   r_cfg.iter_cap   <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_stat.busy;
    assign w_ctl.start   = s_axis_tvalid && !w_stat.busy;
    assign w_ctl.ack     = w_stat.done && (!r_out_valid || m_axis_tready);

    mec_iter #(
        .MAX_POINTS (MAX_POINTS)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_cfg   (r_cfg),
        .i_col   (s_axis_tdata[COL_W-1:0]),
        .i_ci    (s_axis_tdata[COL_W+COORD_W-1:COL_W]),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.ack) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ack) begin
            r_out_data <= w_stat.count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
